// File: hdl/matrix_vector_multiply_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply block.
// Simulation builds get concurrent assertions that report through $error;
// synthesis builds get empty bodies.
// ---------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define MVM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define MVM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define MVM_ASSERT(lbl, clk, rstn, prop, msg)
`define MVM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: hdl/mvm_pkg.sv
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared types, constants and helpers of the matrix-vector multiply block.
// ---------------------------------------------------------------------------
package mvm_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 16;

	localparam int CFG_W  = 7;   // size registers and element count
	localparam int IDX_W  = 6;   // row and column index fields
	localparam int DOT_W  = 32;  // Q16.16 result
	localparam int ACC_W  = 64;  // saturating accumulator

	localparam logic [CFG_W-1:0] CFG_RESET   = 7'd64;
	localparam logic [CFG_W-1:0] COUNT_LIMIT = 7'd127;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_LEN = 2'd1,
		STAT_IDX = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_weight;  // store the request's weight entry
		logic wr_vector;  // store the request's element and count it
		logic cnt_clr;    // close the open vector
		logic cap_err;    // capture row and code of an error result
		logic row_clr;
		logic row_inc;
		logic col_clr;
		logic issue;      // read one weight and one element, step the column
		logic load_ok;    // load a dot product into the result register
		logic load_err;   // load the captured error into the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_vec;
		logic is_last;
		logic idx_bad;
		logic len_bad;
		logic col_last;
		logic row_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

	// A size of zero acts as one, a size above the maximum as the maximum.
	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
			input int unsigned max_size);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (32'(v) > max_size) begin
			r = CFG_W'(max_size);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: hdl/matrix_vector_multiply.sv
// ---------------------------------------------------------------------------
// matrix_vector_multiply
// Dense matrix-vector product, Q8.8 operands, saturated Q16.16 results.
// ---------------------------------------------------------------------------
// A request either writes one weight entry (command 0, at row_index and
// col_index) or delivers the next vector element (command 1). A weight write
// inside the matrix or a vector element that does not close the vector is
// taken with no stall. A weight write that gives an index error or a closing
// element that gives a length mismatch holds the request side until the
// result register is free and takes the error result. When the element marked
// with last closes a vector of exactly cols_in_use elements, the block emits
// one result per row in use, row 0 first, each the saturated dot product of
// that row with the vector, and flags the final one with last_res. A vector
// of the wrong length gives one result with status 1, and a weight write
// outside rows_in_use by cols_in_use gives one result with status 2 and the
// offending row; both carry last_res. The product pass runs one
// multiply-accumulate per cycle while a row issues, through a single
// multiplier fed from the weight and vector memories, so a closing element
// keeps the request side stalled through the pass and any result-side stall:
// per row, the column reads, the drain of two pipeline stages, a check that
// the pipeline is empty and the load of the result register. Size registers
// are meant to be written only while no vector result is pending; a size of
// zero acts as one and a size above the maximum as the maximum. Weights must
// be written before they are used; the memories are not cleared at reset.
// ---------------------------------------------------------------------------
module matrix_vector_multiply import mvm_pkg::*; #(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  command,
	input  logic [IDX_W-1:0]      row_index,
	input  logic [IDX_W-1:0]      col_index,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  last,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [IDX_W-1:0]      row,
	output logic [DOT_W-1:0]      dot_value,
	output logic [1:0]            status,
	output logic                  last_res,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Size registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences each request and the row passes of a product.
	mvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the memories, counters, the multiply-accumulate
	// pipeline and the result register that decouples the result side.
	mvm_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.command   (command),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.last      (last),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.row       (row),
		.dot_value (dot_value),
		.status    (status),
		.last_res  (last_res)
	);

endmodule

// File: hdl/mvm_ram.sv
// ---------------------------------------------------------------------------
// mvm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module mvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/mvm_datapath.sv
// ---------------------------------------------------------------------------
// mvm_datapath
// Size registers, weight and vector memories, element count, row and
// column counters, the multiply-accumulate pipeline and the result register.
// ---------------------------------------------------------------------------
`include "matrix_vector_multiply_defines.svh"

module mvm_datapath import mvm_pkg::*; #(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	// request fields
	input  logic                  command,
	input  logic [IDX_W-1:0]      row_index,
	input  logic [IDX_W-1:0]      col_index,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  last,
	// configuration write
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// result register
	input  logic                  res_stall,
	output logic                  res_valid,
	output logic [IDX_W-1:0]      row,
	output logic [DOT_W-1:0]      dot_value,
	output logic [1:0]            status,
	output logic                  last_res
);

	localparam int WDEPTH = MAX_ROWS * MAX_COLS;
	localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int VA     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int PROD_W = 2 * DATA_WIDTH;

	logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
	logic [CFG_W-1:0] rows_eff, cols_eff;
	logic [CFG_W-1:0] count_q, count_inc;
	logic [IDX_W-1:0] row_q;
	logic [CFG_W-1:0] col_q;

	logic [WA-1:0]         w_waddr, w_raddr;
	logic [VA-1:0]         v_waddr, v_raddr;
	logic                  v_we;
	logic [DATA_WIDTH-1:0] w_rdata, v_rdata;

	logic                     s1_valid_q, s2_valid_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, acc_sat;
	logic signed [ACC_W:0]    acc_sum;
	logic                     acc_clr;
	logic [DOT_W-1:0]         dot_clamp;

	logic [IDX_W-1:0] err_row_q;
	status_t          err_stat_q;

	logic             res_valid_q;
	logic [IDX_W-1:0] res_row_q;
	logic [DOT_W-1:0] res_dot_q;
	status_t          res_stat_q;
	logic             res_last_q;

	// Size registers and their effective values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CFG_RESET;
			cols_cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS) begin
				rows_cfg_q <= cfg_data;
			end else begin
				cols_cfg_q <= cfg_data;
			end
		end
	end

	assign rows_eff = clamp_size(rows_cfg_q, MAX_ROWS);
	assign cols_eff = clamp_size(cols_cfg_q, MAX_COLS);

	// Element count of the open vector; it sticks at its limit.
	assign count_inc = (count_q == COUNT_LIMIT) ? count_q : count_q + CFG_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_clr) begin
			count_q <= '0;
		end else if (cmd.wr_vector) begin
			count_q <= count_inc;
		end
	end

	// Row and column counters of the product pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else begin
			if (cmd.row_clr) begin
				row_q <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + IDX_W'(1);
			end
			if (cmd.col_clr) begin
				col_q <= '0;
			end else if (cmd.issue) begin
				col_q <= col_q + CFG_W'(1);
			end
		end
	end

	// Memories. Entry (r, c) of the weight store sits at r * MAX_COLS + c.
	assign w_waddr = WA'(32'(row_index) * 32'(MAX_COLS) + 32'(col_index));
	assign w_raddr = WA'(32'(row_q) * 32'(MAX_COLS) + 32'(col_q));
	assign v_we    = cmd.wr_vector && (32'(count_q) < 32'(MAX_COLS));
	assign v_waddr = VA'(count_q);
	assign v_raddr = VA'(col_q);

	mvm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (WDEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (cmd.wr_weight),
		.waddr (w_waddr),
		.wdata (value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	mvm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_COLS)
	) u_vector_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (value),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// Multiply-accumulate pipeline: read, multiply, accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= cmd.issue;
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rdata) * $signed(v_rdata);
	end

	assign acc_clr = cmd.issue && (col_q == '0);
	assign acc_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W + 1)'(prod_s2);

	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
				: {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_clr) begin
			acc_q <= '0;
		end else if (s2_valid_q) begin
			acc_q <= acc_sat;
		end
	end

	// Clamp the accumulator to the signed result width.
	always_comb begin
		if (!acc_q[ACC_W-1] && (|acc_q[ACC_W-2:DOT_W-1])) begin
			dot_clamp = {1'b0, {(DOT_W - 1){1'b1}}};
		end else if (acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:DOT_W-1])) begin
			dot_clamp = {1'b1, {(DOT_W - 1){1'b0}}};
		end else begin
			dot_clamp = acc_q[DOT_W-1:0];
		end
	end

	// Error capture.
	always_ff @(posedge clk) begin
		if (cmd.cap_err) begin
			err_row_q  <= command ? '0 : row_index;
			err_stat_q <= command ? STAT_LEN : STAT_IDX;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_ok || cmd.load_err) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_ok) begin
			res_row_q  <= row_q;
			res_dot_q  <= dot_clamp;
			res_stat_q <= STAT_OK;
			res_last_q <= sts.row_last;
		end else if (cmd.load_err) begin
			res_row_q  <= err_row_q;
			res_dot_q  <= '0;
			res_stat_q <= err_stat_q;
			res_last_q <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign row       = res_row_q;
	assign dot_value = res_dot_q;
	assign status    = res_stat_q;
	assign last_res  = res_last_q;

	// Status.
	assign sts.is_vec    = command;
	assign sts.is_last   = last;
	assign sts.idx_bad   = ({1'b0, row_index} >= rows_eff) || ({1'b0, col_index} >= cols_eff);
	assign sts.len_bad   = (count_inc != cols_eff);
	assign sts.col_last  = ((CFG_W + 1)'(col_q) + (CFG_W + 1)'(1)) == {1'b0, cols_eff};
	assign sts.row_last  = ({1'b0, row_q} + CFG_W'(1)) == rows_eff;
	assign sts.pipe_busy = s1_valid_q || s2_valid_q;
	assign sts.out_free  = !res_valid_q || !res_stall;

	`MVM_ASSERT(a_issue_in_range, clk, arst_n, cmd.issue |-> (col_q < cols_eff), "column read beyond the matrix")
	`MVM_ASSERT_NEVER(a_clear_while_busy, clk, arst_n, acc_clr && (s1_valid_q || s2_valid_q), "accumulator cleared with products in flight")

endmodule

// File: hdl/mvm_ctrl.sv
// ---------------------------------------------------------------------------
// mvm_ctrl
// Controller: takes requests, steers weight and element writes, and walks
// the rows and columns of a product pass.
// ---------------------------------------------------------------------------
`include "matrix_vector_multiply_defines.svh"

module mvm_ctrl import mvm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ERR   = 5'b00010,
		S_ISSUE = 5'b00100,
		S_DRAIN = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (!sts.is_vec) begin
						if (sts.idx_bad) begin
							cmd.cap_err = 1'b1;
							state_d     = S_ERR;
						end else begin
							cmd.wr_weight = 1'b1;
						end
					end else begin
						cmd.wr_vector = 1'b1;
						if (sts.is_last) begin
							cmd.cnt_clr = 1'b1;
							if (sts.len_bad) begin
								cmd.cap_err = 1'b1;
								state_d     = S_ERR;
							end else begin
								cmd.row_clr = 1'b1;
								cmd.col_clr = 1'b1;
								state_d     = S_ISSUE;
							end
						end
					end
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.col_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_ok = 1'b1;
					if (sts.row_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.row_inc = 1'b1;
						cmd.col_clr = 1'b1;
						state_d     = S_ISSUE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`MVM_ASSERT(a_load_when_free, clk, arst_n, (cmd.load_ok || cmd.load_err) |-> sts.out_free, "result loaded over a waiting result")
	`MVM_ASSERT(a_load_after_drain, clk, arst_n, cmd.load_ok |-> !sts.pipe_busy, "dot product loaded before the pipeline drained")
	`MVM_ASSERT_NEVER(a_write_and_load, clk, arst_n, (cmd.wr_weight || cmd.wr_vector) && (cmd.load_ok || cmd.load_err), "store write during a result load")

endmodule

// File: tb/sv/matrix_vector_multiply_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the matrix-vector multiply block
// Drives weight writes and vector elements into the request channel, changes
// the matrix size through the configuration channel between phases, and
// checks every result against a cycle-free predictor of the Q8.8 / Q16.16
// arithmetic. A short table of directed requests comes first, followed by
// randomized phases with different idle and stall patterns.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_tb import mvm_pkg::*; ();

	// Request commands.
	localparam logic CMD_WEIGHT  = 1'b0;
	localparam logic CMD_ELEMENT = 1'b1;

	localparam int ROWS_MAX    = 64;
	localparam int COLS_MAX    = 64;
	localparam int ELEM_SAT    = 127;  // element counter saturates here
	localparam int SETTLE      = 8;    // cycles after the last result before a size write
	localparam int TAIL        = 64;   // cycles to watch for strays at the end
	localparam int LONG_HOLD   = 400;  // receiver hold-off under pressure
	localparam int QUIET_LIMIT = 5000; // cycles with no handshake at all

	// One result as it appears on the result channel.
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [DOT_W-1:0] dot;
		status_t          status;
		logic             last;
	} dot_result_t;

	// An expectation typed into the directed table, carried with its request.
	typedef struct packed {
		logic        on;
		dot_result_t res;
	} typed_dot_t;

	// One row of the directed table: a request or a size register write.
	typedef struct packed {
		logic             is_cfg;
		logic             cfg_sel;
		logic [CFG_W-1:0] cfg_val;
		logic             cmd;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [15:0]      v;
		logic             lst;
		typed_dot_t       typed;
	} step_t;

	// One randomized phase. A size of -1 picks a small random size.
	typedef struct packed {
		int rows_reg;
		int cols_reg;
		int send_pct;
		int stall_pct;
		int budget;
		bit hold;
	} phase_t;

	localparam phase_t PLAN [6] = '{
		'{3,   4,   0,  0,  14, 1'b0},
		'{16,  1,   54, 0,  6,  1'b1},
		'{0,   2,   0,  54, 8,  1'b0},
		'{5,   3,   24, 24, 12, 1'b0},
		'{-1,  -1,  54, 0,  10, 1'b0},
		'{-1,  -1,  0,  54, 10, 1'b0}
	};

	// Every input of the block starts at a known value.
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             command   = CMD_WEIGHT;
	logic [IDX_W-1:0] row_index = '0;
	logic [IDX_W-1:0] col_index = '0;
	logic [15:0]      value     = '0;
	logic             last      = 1'b0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [IDX_W-1:0] row;
	logic [DOT_W-1:0] dot_value;
	logic [1:0]       status;
	logic             last_res;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = CFG_ROWS;
	logic [CFG_W-1:0] cfg_data  = '0;

	matrix_vector_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.last      (last),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.row       (row),
		.dot_value (dot_value),
		.status    (status),
		.last_res  (last_res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The clock runs with a period of 12 time units.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state. It mirrors the block's stores and registers and is
	// updated only from handshakes seen on the ports.
	logic signed [15:0] weight_mem [ROWS_MAX*COLS_MAX];
	logic signed [15:0] vector_mem [COLS_MAX];
	int                 elem_count = 0;
	logic [CFG_W-1:0]   rows_reg   = CFG_RESET;
	logic [CFG_W-1:0]   cols_reg   = CFG_RESET;

	dot_result_t dots_due [$];    // results the block still owes, oldest first
	typed_dot_t  typed_dots [$];  // one entry per request, in request order

	int errors       = 0;
	int quiet_cycles = 0;

	// Stimulus-side view: which weights hold a value, so that no vector ever
	// makes the block read a weight that was never written, and the sizes
	// the generator currently works with.
	bit weight_known [ROWS_MAX*COLS_MAX];
	int gen_rows   = ROWS_MAX;
	int gen_cols   = COLS_MAX;
	int items_sent = 0;

	// Idle and stall knobs, in percent of cycles, plus the hold-off trigger.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_start    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	// A size register of zero acts as one, anything above the maximum as
	// the maximum.
	function automatic int size_in_effect(input logic [CFG_W-1:0] v, input int max_size);
		if (v == '0)
			return 1;
		return (int'(v) > max_size) ? max_size : int'(v);
	endfunction

	// Operand values lean toward the extremes of Q8.8 so that saturation and
	// the most negative value show up often.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Works out what one accepted request makes the block emit and queues it.
	// A weight write outside the sizes in effect gives an index error; an
	// element either just joins the open vector or, carrying last, closes it
	// with a length check and then one saturated dot product per row.
	task automatic compute_dots(input logic cmd, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [15:0] v, input logic lst);
		dot_result_t fresh [$];
		dot_result_t one;
		typed_dot_t  t;
		int          nrows;
		int          ncols;
		longint      acc;
		nrows = size_in_effect(rows_reg, ROWS_MAX);
		ncols = size_in_effect(cols_reg, COLS_MAX);
		if (cmd == CMD_WEIGHT) begin
			if (int'(r) >= nrows || int'(c) >= ncols) begin
				one = '{row: r, dot: '0, status: STAT_IDX, last: 1'b1};
				fresh.push_back(one);
			end else begin
				weight_mem[int'(r)*COLS_MAX + int'(c)] = v;
			end
		end else begin
			// Elements past the store are dropped; the count still climbs
			// until it saturates, which forces a length mismatch.
			if (elem_count < COLS_MAX)
				vector_mem[elem_count] = v;
			if (elem_count < ELEM_SAT)
				elem_count++;
			if (lst) begin
				if (elem_count != ncols) begin
					one = '{row: '0, dot: '0, status: STAT_LEN, last: 1'b1};
					fresh.push_back(one);
				end else begin
					for (int i = 0; i < nrows; i++) begin
						// At most 64 products of 2^30 each, so the 64-bit sum
						// cannot reach its own limits; only the 32-bit clamp acts.
						acc = 0;
						for (int j = 0; j < ncols; j++)
							acc += longint'(weight_mem[i*COLS_MAX + j]) *
								longint'(vector_mem[j]);
						one.row    = IDX_W'(i);
						one.status = STAT_OK;
						one.last   = (i + 1 == nrows);
						if (acc > longint'(32'sh7fffffff))
							one.dot = 32'h7fffffff;
						else if (acc < -longint'(64'sh80000000))
							one.dot = 32'h80000000;
						else
							one.dot = acc[31:0];
						fresh.push_back(one);
					end
				end
				elem_count = 0;
			end
		end
		// Rows of the directed table may carry their own expectation, which
		// then stands in for the computed one.
		t = typed_dots.pop_front();
		if (t.on)
			dots_due.push_back(t.res);
		else
			foreach (fresh[k])
				dots_due.push_back(fresh[k]);
	endtask

	// Compares one accepted result with the oldest expectation.
	task automatic check_result();
		dot_result_t want;
		if (dots_due.size() == 0) begin
			$error("unexpected result: row %0d dot_value %0d status %0d last_res %0b",
				row, $signed(dot_value), status, last_res);
			errors++;
		end else begin
			want = dots_due.pop_front();
			if (row !== want.row) begin
				$error("row: expected %0d, actual %0d", want.row, row);
				errors++;
			end
			if (dot_value !== want.dot) begin
				$error("dot_value: expected %0d, actual %0d", $signed(want.dot),
					$signed(dot_value));
				errors++;
			end
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				errors++;
			end
			if (last_res !== want.last) begin
				$error("last_res: expected %0b, actual %0b", want.last, last_res);
				errors++;
			end
		end
	endtask

	// Port monitor. It samples at the rising edge, so it sees the values that
	// the handshake was made with. Results are checked before the new request
	// is predicted; a result at this edge always belongs to an older request.
	// The watchdog counts edges at which no channel moves anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_result();
			if (req_valid && !req_stall)
				compute_dots(command, row_index, col_index, value, last);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ROWS)
					rows_reg = cfg_data;
				else
					cols_reg = cfg_data;
			end
			if ((res_valid && !res_stall) || (req_valid && !req_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no handshake for %0d cycles, %0d results outstanding",
					quiet_cycles, dots_due.size());
				$display("** matrix_vector_multiply: FAILED **");
				$finish;
			end
		end
	end

	// Result receiver. It stalls at random by stall_pct, and when the
	// stimulus bumps hold_start it holds off for a long stretch on its own
	// count, so that the block backs up and stalls its request side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_seen != hold_start) begin
			hold_seen <= hold_start;
			hold_left <= LONG_HOLD;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offers one request and returns at the edge that accepts it. Random idle
	// cycles come first; valid stays high on return so that back-to-back
	// requests need no extra assignment in the same step.
	task automatic send_request(input logic cmd, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [15:0] v, input logic lst,
			input typed_dot_t typed);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		typed_dots.push_back(typed);
		if (cmd == CMD_WEIGHT && int'(r) < gen_rows && int'(c) < gen_cols)
			weight_known[int'(r)*COLS_MAX + int'(c)] = 1'b1;
		req_valid <= 1'b1;
		command   <= cmd;
		row_index <= r;
		col_index <= c;
		value     <= v;
		last      <= lst;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Writes a size register once the block has delivered everything and had
	// a few cycles to finish any weight write still in flight. The first edge
	// lets the monitor book the request accepted at the edge we came from.
	task automatic write_size(input logic sel, input logic [CFG_W-1:0] val);
		req_valid <= 1'b0;
		@(posedge clk);
		while (dots_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (sel == CFG_ROWS)
			gen_rows = size_in_effect(val, ROWS_MAX);
		else
			gen_cols = size_in_effect(val, COLS_MAX);
	endtask

	// Sends a vector of len elements with random content, last on the final
	// one. The index fields are don't-care for elements and get noise.
	task automatic send_vector(input int len);
		for (int k = 0; k < len; k++)
			send_request(CMD_ELEMENT, IDX_W'($urandom), IDX_W'($urandom), pick_value(),
				k == len - 1, '0);
	endtask

	// Writes every weight of the region in use that has never been written,
	// so that the next vector reads only defined entries.
	task automatic fill_weights();
		for (int i = 0; i < gen_rows; i++)
			for (int j = 0; j < gen_cols; j++)
				if (!weight_known[i*COLS_MAX + j])
					send_request(CMD_WEIGHT, IDX_W'(i), IDX_W'(j), pick_value(),
						1'($urandom), '0);
	endtask

	// Builders for the directed table.
	function automatic step_t weight_req(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [15:0] v, input logic lst);
		step_t s;
		s     = '0;
		s.cmd = CMD_WEIGHT;
		s.r   = r;
		s.c   = c;
		s.v   = v;
		s.lst = lst;
		return s;
	endfunction

	function automatic step_t element_req(input logic [15:0] v, input logic lst);
		step_t s;
		s     = '0;
		s.cmd = CMD_ELEMENT;
		s.v   = v;
		s.lst = lst;
		return s;
	endfunction

	function automatic step_t size_write(input logic sel, input logic [CFG_W-1:0] val);
		step_t s;
		s         = '0;
		s.is_cfg  = 1'b1;
		s.cfg_sel = sel;
		s.cfg_val = val;
		return s;
	endfunction

	// Error results always carry a zero dot product and last_res set.
	function automatic step_t with_error(input step_t s, input status_t code,
			input logic [IDX_W-1:0] r);
		s.typed.on  = 1'b1;
		s.typed.res = '{row: r, dot: '0, status: code, last: 1'b1};
		return s;
	endfunction

	// Main stimulus.
	initial begin
		step_t       script [$];
		phase_t      ph;
		int          budget_end;
		int          pick;
		int          len;
		logic [CFG_W-1:0] rsel;
		logic [CFG_W-1:0] csel;

		// Directed table. Error results are typed in; dot products are left
		// to the predictor.
		script = '{
			// At reset the sizes are 64 by 64, so the far corner is in range.
			weight_req(6'd63, 6'd63, 16'h7fff, 1'b0),
			// A one-element vector against 64 columns is a length mismatch.
			with_error(element_req(16'h1234, 1'b1), STAT_LEN, 6'd0),
			// The last mark on a weight write is ignored.
			weight_req(6'd0, 6'd0, 16'h8000, 1'b1),
			size_write(CFG_ROWS, 7'd2),
			size_write(CFG_COLS, 7'd3),
			// Weight writes outside 2 by 3, once by row and once by column.
			with_error(weight_req(6'd5, 6'd0, 16'h0101, 1'b0), STAT_IDX, 6'd5),
			with_error(weight_req(6'd0, 6'd3, 16'h0101, 1'b0), STAT_IDX, 6'd0),
			// Row 0 saturates negative and row 1 positive against a vector of
			// the most negative value.
			weight_req(6'd0, 6'd0, 16'h7fff, 1'b0),
			weight_req(6'd0, 6'd1, 16'h7fff, 1'b0),
			weight_req(6'd0, 6'd2, 16'h7fff, 1'b0),
			weight_req(6'd1, 6'd0, 16'h8000, 1'b0),
			weight_req(6'd1, 6'd1, 16'h8000, 1'b0),
			weight_req(6'd1, 6'd2, 16'h8000, 1'b0),
			element_req(16'h8000, 1'b0),
			element_req(16'h8000, 1'b0),
			element_req(16'h8000, 1'b1),
			// Sizes of zero act as one.
			size_write(CFG_ROWS, 7'd0),
			size_write(CFG_COLS, 7'd0),
			element_req(16'h7fff, 1'b1),
			with_error(weight_req(6'd1, 6'd0, 16'h0001, 1'b0), STAT_IDX, 6'd1),
			// A size change leaves the open vector alone; the length check
			// uses the column count in effect at the last mark.
			size_write(CFG_ROWS, 7'd2),
			size_write(CFG_COLS, 7'd3),
			element_req(16'h0100, 1'b0),
			element_req(16'hff00, 1'b0),
			size_write(CFG_COLS, 7'd2),
			with_error(element_req(16'h0001, 1'b1), STAT_LEN, 6'd0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[n]) begin
			if (script[n].is_cfg)
				write_size(script[n].cfg_sel, script[n].cfg_val);
			else
				send_request(script[n].cmd, script[n].r, script[n].c, script[n].v,
					script[n].lst, script[n].typed);
		end

		// Random phases. Each sets its idle pattern and sizes, writes any
		// weight the new region lacks, then mostly sends well-formed vectors,
		// mixed with stray weight writes and vectors of the wrong length.
		foreach (PLAN[p]) begin
			ph = PLAN[p];
			rsel = (ph.rows_reg < 0) ? CFG_W'($urandom_range(4, 1)) : CFG_W'(ph.rows_reg);
			csel = (ph.cols_reg < 0) ? CFG_W'($urandom_range(4, 1)) : CFG_W'(ph.cols_reg);
			write_size(CFG_ROWS, rsel);
			write_size(CFG_COLS, csel);
			send_idle_pct = ph.send_pct;
			stall_pct     = ph.stall_pct;
			fill_weights();
			// Under pressure the receiver stops while requests keep coming.
			if (ph.hold)
				hold_start++;
			budget_end = items_sent + ph.budget;
			while (items_sent < budget_end) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					repeat ($urandom_range(2))
						send_request(CMD_WEIGHT, IDX_W'($urandom_range(gen_rows - 1)),
							IDX_W'($urandom_range(gen_cols - 1)), pick_value(),
							1'($urandom), '0);
					send_vector(gen_cols);
				end else if (pick < 85) begin
					// Anywhere in the index space; outside the region it is an
					// index error, inside it a plain write.
					send_request(CMD_WEIGHT, IDX_W'($urandom), IDX_W'($urandom),
						pick_value(), 1'($urandom), '0);
				end else begin
					len = $urandom_range(gen_cols + 2, 1);
					if (len == gen_cols)
						len = gen_cols + 1;
					send_vector(len);
				end
			end
		end

		// Drain: wait for every owed result, then watch a little longer for
		// anything the block should not have sent.
		req_valid <= 1'b0;
		@(posedge clk);
		while (dots_due.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0 && dots_due.size() == 0)
			$display("** matrix_vector_multiply: PASSED **");
		else
			$display("** matrix_vector_multiply: FAILED **");
		$finish;
	end

endmodule
